// ===== sv/nwsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nwsp_pkg
// Shared types, character codes and the field parse function for the
// wind sentence parser.
// ----------------------------------------------------------------------------
package nwsp_pkg;

    localparam int SENTENCE_BYTES_DEF = 64;
    localparam int STORE_DEPTH        = 20;
    localparam int FIELD_LEN          = 5;
    localparam int DIR_OFFSET         = 7;
    localparam int SPD_OFFSET         = 15;
    localparam int HEADER_LEN         = 6;
    localparam int OUT_W              = 28;
    localparam int MAG_W              = 27;
    localparam int TOTAL_W            = 30;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // exact divide by ten for any 32-bit value
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_POINT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [0:HEADER_LEN-1][7:0] HEADER_BYTES = "$IIMWV";

    typedef logic [FIELD_LEN-1:0][7:0] field_bytes_t;

    typedef struct packed {
        field_bytes_t dir;
        field_bytes_t spd;
    } fields_t;

    typedef enum logic [1:0] {
        PH_INT,
        PH_FRAC,
        PH_DONE
    } parse_phase_t;

    typedef struct packed {
        logic        neg;
        logic [16:0] ip;
        logic [13:0] frac;
        logic [2:0]  nfrac;
    } field_parse_t;

    // sign, integer digits, optional point, fraction digits; stops at
    // the first other byte
    function automatic field_parse_t parse_field(input field_bytes_t b);
        field_parse_t r;
        parse_phase_t ph;
        logic         sgn;
        logic         dig;
        logic [3:0]   d;
        logic [7:0]   c;
        r   = '0;
        ph  = PH_INT;
        sgn = (b[0] == CHAR_MINUS) || (b[0] == CHAR_PLUS);
        r.neg = (b[0] == CHAR_MINUS);
        for (int i = 0; i < FIELD_LEN; i++) begin
            if (!(i == 0 && sgn)) begin
                c   = b[i];
                dig = c inside {[CHAR_ZERO:CHAR_NINE]};
                d   = c[3:0];
                case (ph)
                    PH_INT:
                    begin
                        if (dig) begin
                            r.ip = 17'(r.ip * 17'd10 + 17'(d));
                        end else if (c == CHAR_POINT) begin
                            ph = PH_FRAC;
                        end else begin
                            ph = PH_DONE;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (dig) begin
                            r.frac  = 14'(r.frac * 14'd10 + 14'(d));
                            r.nfrac = r.nfrac + 3'd1;
                        end else begin
                            ph = PH_DONE;
                        end
                    end
                    default:
                    begin
                        ph = PH_DONE;
                    end
                endcase
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/nwsp_front.sv =====
// ----------------------------------------------------------------------------
// nwsp_front
// Collects sentence bytes; when a '$' closes a held sentence it checks
// the header and on a match pushes both raw field byte groups to the queue.
// ----------------------------------------------------------------------------
module nwsp_front #(
    parameter int SENTENCE_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [7:0]        rx_byte,
    input  logic              q_full,
    output logic              q_push,
    output nwsp_pkg::fields_t q_data
);
    import nwsp_pkg::*;

    localparam int CW     = $clog2(SENTENCE_BYTES + 1);
    localparam int SIDX_W = $clog2(STORE_DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    store_reg [STORE_DEPTH];

    logic          accept;
    logic          restart;
    logic          hdr_ok;
    logic [CW-1:0] base;
    logic          do_write;

    assign rx_stall = q_full;
    assign accept   = rx_valid && !rx_stall;

    always_comb
    begin
        hdr_ok = 1'b1;
        for (int i = 0; i < HEADER_LEN; i++) begin
            if (store_reg[i] != HEADER_BYTES[i]) begin
                hdr_ok = 1'b0;
            end
        end
    end

    assign restart  = (rx_byte == CHAR_DOLLAR) && (count_reg != '0);
    assign base     = restart ? '0 : count_reg;
    assign do_write = base < CW'(SENTENCE_BYTES);
    assign q_push   = accept && restart && hdr_ok;

    always_comb
    begin
        for (int i = 0; i < FIELD_LEN; i++) begin
            q_data.dir[i] = store_reg[DIR_OFFSET + i];
            q_data.spd[i] = store_reg[SPD_OFFSET + i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept) begin
            count_next = do_write ? CW'(base + CW'(1)) : base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            count_reg <= count_next;
            // positions past the store are counted only
            if (accept && do_write && (base < CW'(STORE_DEPTH))) begin
                for (int i = 0; i < STORE_DEPTH; i++) begin
                    if (base[SIDX_W-1:0] == SIDX_W'(i)) begin
                        store_reg[i] <= rx_byte;
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SENTENCE_BYTES))
        else $error("byte count beyond sentence length");

    a_dollar_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (rx_byte == CHAR_DOLLAR) |=>
            (count_reg == CW'(1)) && (store_reg[0] == CHAR_DOLLAR))
        else $error("dollar did not start a new sentence");

    a_push_header: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (store_reg[0] == CHAR_DOLLAR) && (count_reg != '0))
        else $error("push without a held sentence");
`endif

endmodule

// ===== sv/nwsp_queue.sv =====
// ----------------------------------------------------------------------------
// nwsp_queue
// Short register queue between the byte front end and the conversion
// pipeline.
// ----------------------------------------------------------------------------
module nwsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nwsp_pkg::fields_t push_data,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop,
    output nwsp_pkg::fields_t pop_data
);
    import nwsp_pkg::*;

    fields_t             data_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(wr_ptr_reg + QPTR_W'(1));
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(rd_ptr_reg + QPTR_W'(1));
        end
        if (push && !pop) begin
            count_next = QCNT_W'(count_reg + QCNT_W'(1));
        end else if (pop && !push) begin
            count_next = QCNT_W'(count_reg - QCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !pop_valid))
        else $error("pop from empty queue");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == QCNT_W'($past(count_reg) + QCNT_W'(1)))
        else $error("queue fill count slipped");
`endif

endmodule

// ===== sv/nwsp_back.sv =====
// ----------------------------------------------------------------------------
// nwsp_back
// Three-stage conversion of both fields: digit parse, scaling to
// ten-thousandths, rounded divide by ten and sign.
// ----------------------------------------------------------------------------
module nwsp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  nwsp_pkg::fields_t          q_data,
    output logic                       wind_valid,
    input  logic                       wind_stall,
    output logic signed [nwsp_pkg::OUT_W-1:0] wind_direction_milli,
    output logic signed [nwsp_pkg::OUT_W-1:0] wind_speed_milli
);
    import nwsp_pkg::*;

    localparam int NL = 2;

    logic                 s1_v_reg;
    field_parse_t         s1_reg [NL];
    logic                 s2_v_reg;
    logic [TOTAL_W-1:0]   s2_total_reg [NL];
    logic                 s2_neg_reg [NL];
    logic                 out_v_reg;
    logic [OUT_W-1:0]     out_reg [NL];

    logic                 en1;
    logic                 en2;
    logic                 en3;
    field_parse_t         parse_next [NL];
    logic [TOTAL_W-1:0]   total_next [NL];
    logic [OUT_W-1:0]     out_next [NL];

    assign en3   = !out_v_reg || !wind_stall;
    assign en2   = !s2_v_reg || en3;
    assign en1   = !s1_v_reg || en2;
    assign q_pop = q_valid && en1;

    assign parse_next[0] = parse_field(q_data.dir);
    assign parse_next[1] = parse_field(q_data.spd);

    always_comb
    begin
        for (int l = 0; l < NL; l++) begin
            logic [TOTAL_W-1:0] scale;
            case (s1_reg[l].nfrac)
                3'd0:    scale = TOTAL_W'(10000);
                3'd1:    scale = TOTAL_W'(1000);
                3'd2:    scale = TOTAL_W'(100);
                3'd3:    scale = TOTAL_W'(10);
                default: scale = TOTAL_W'(1);
            endcase
            total_next[l] = TOTAL_W'(TOTAL_W'(s1_reg[l].ip) * TOTAL_W'(10000)
                          + TOTAL_W'(s1_reg[l].frac) * scale + TOTAL_W'(5));
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++) begin
            logic [61:0]      prod;
            logic [MAG_W-1:0] mag;
            prod = 62'(s2_total_reg[l]) * 62'(RECIP_TEN);
            mag  = MAG_W'(prod >> RECIP_SHIFT);
            out_next[l] = s2_neg_reg[l] ? OUT_W'(-{1'b0, mag}) : {1'b0, mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (en1) begin
                s1_v_reg <= q_valid;
            end
            if (en2) begin
                s2_v_reg <= s1_v_reg;
            end
            if (en3) begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++) begin
            if (en1 && q_valid) begin
                s1_reg[l] <= parse_next[l];
            end
            if (en2 && s1_v_reg) begin
                s2_total_reg[l] <= total_next[l];
                s2_neg_reg[l]   <= s1_reg[l].neg;
            end
            if (en3 && s2_v_reg) begin
                out_reg[l] <= out_next[l];
            end
        end
    end

    assign wind_valid           = out_v_reg;
    assign wind_direction_milli = out_reg[0];
    assign wind_speed_milli     = out_reg[1];

endmodule

// ===== sv/nmea_wind_sentence_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_wind_sentence_parser
// Serial byte in, wind direction and speed out for each "$IIMWV" sentence.
// ----------------------------------------------------------------------------
// Throughput: one rx item per cycle, sustained; the front end never waits
//   on conversion unless the two-entry queue is full.
// Path: the closing '$' item enters the queue at the edge that takes it,
//   then passes the parse, scale and divide-by-ten registers.
// Reset: rst_n clears the byte count, the 20-byte store, the queue and the
//   pipeline valids at once; no clearing pass, items taken straight after.
module nmea_wind_sentence_parser #(
    parameter int SENTENCE_BYTES = nwsp_pkg::SENTENCE_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rx_valid,
    output logic                              rx_stall,
    input  logic [7:0]                        rx_byte,
    output logic                              wind_valid,
    input  logic                              wind_stall,
    output logic signed [nwsp_pkg::OUT_W-1:0] wind_direction_milli,
    output logic signed [nwsp_pkg::OUT_W-1:0] wind_speed_milli
);
    import nwsp_pkg::*;

    // queue between front end and conversion
    logic    q_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    fields_t q_in;
    fields_t q_out;

    // Front end: stores bytes, matches header when a '$' closes a
    // sentence, pushes the two raw 5-byte fields.
    nwsp_front #(
        .SENTENCE_BYTES (SENTENCE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // Short queue lets the output side stall without holding up bytes until full.
    nwsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_out)
    );

    // Back end: field conversion pipeline, last stage is the output
    // register.
    nwsp_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .q_valid              (q_valid),
        .q_pop                (q_pop),
        .q_data               (q_out),
        .wind_valid           (wind_valid),
        .wind_stall           (wind_stall),
        .wind_direction_milli (wind_direction_milli),
        .wind_speed_milli     (wind_speed_milli)
    );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: bench for nmea_wind_sentence_parser
// Streams serial bytes into the parser and keeps its own model of the
// sentence store and field conversion. Every reading the block gives is
// checked against the expected readings in arrival order, field by field.
// Both sides idle at random. Once the reading side holds off for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nwsp_pkg::*;

    localparam int SENT_BYTES = 64;   // buffer length given to the block
    localparam int LATENCY    = 3;    // closing '$' to reading, sizes the final wait

    typedef logic [0:FIELD_LEN-1][7:0]  field_t;
    typedef logic [0:HEADER_LEN-1][7:0] header_t;

    typedef struct {
        logic signed [OUT_W-1:0] direction;
        logic signed [OUT_W-1:0] speed;
    } wind_reading_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    rx_valid   = 1'b0;
    logic [7:0]              rx_byte    = 8'h00;
    logic                    wind_stall = 1'b0;
    logic                    rx_stall;
    logic                    wind_valid;
    logic signed [OUT_W-1:0] wind_direction_milli;
    logic signed [OUT_W-1:0] wind_speed_milli;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    nmea_wind_sentence_parser #(
        .SENTENCE_BYTES (SENT_BYTES)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .rx_valid             (rx_valid),
        .rx_stall             (rx_stall),
        .rx_byte              (rx_byte),
        .wind_valid           (wind_valid),
        .wind_stall           (wind_stall),
        .wind_direction_milli (wind_direction_milli),
        .wind_speed_milli     (wind_speed_milli)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    int send_idle_pct = 26;   // chance in a hundred that the sender idles a cycle
    int recv_idle_pct = 52;   // same for the reading side
    int hold_req      = 0;    // long hold-off requested by a test, in cycles
    int hold_left     = 0;

    int mismatches         = 0;
    int bytes_sent         = 0;
    int readings_predicted = 0;

    // own copy of the sentence store and byte count
    logic [7:0]    rx_store [0:STORE_DEPTH-1];
    int            rx_count = 0;
    wind_reading_t wind_expected [$];

    initial
    begin
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            rx_store[k] = 8'h00;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Optional sign, digits, optional point, digits; stops at the first
    // other byte or after five bytes. Worked in ten-thousandths, then
    // rounded half away from zero to thousandths, sign applied last.
    function automatic logic signed [OUT_W-1:0] field_to_milli(input int first);
        int                      k;
        int                      nfrac;
        bit                      neg;
        longint unsigned         whole;
        longint unsigned         part;
        longint unsigned         mag;
        logic signed [OUT_W-1:0] v;
        k     = 0;
        nfrac = 0;
        neg   = 1'b0;
        whole = 0;
        part  = 0;
        if (rx_store[first] == CHAR_MINUS || rx_store[first] == CHAR_PLUS)
        begin
            neg = (rx_store[first] == CHAR_MINUS);
            k   = 1;
        end
        while (k < FIELD_LEN && is_digit(rx_store[first + k]))
        begin
            whole = whole * 10 + longint'(rx_store[first + k] & 8'h0F);
            k++;
        end
        if (k < FIELD_LEN && rx_store[first + k] == CHAR_POINT)
        begin
            k++;
            while (k < FIELD_LEN && is_digit(rx_store[first + k]))
            begin
                part = part * 10 + longint'(rx_store[first + k] & 8'h0F);
                nfrac++;
                k++;
            end
        end
        for (int n = nfrac; n < 4; n++)
        begin
            part = part * 10;
        end
        mag = (whole * 10000 + part + 5) / 10;
        v   = OUT_W'(mag);
        if (neg)
        begin
            v = -v;
        end
        return v;
    endfunction

    // One accepted byte: a '$' with bytes held closes the sentence, and a
    // matching header yields one reading. Past the buffer length bytes
    // are dropped; past the store they are counted only.
    function automatic void track_sentence(input logic [7:0] c);
        bit            hdr_ok;
        wind_reading_t r;
        if (c == CHAR_DOLLAR && rx_count != 0)
        begin
            hdr_ok = 1'b1;
            for (int k = 0; k < HEADER_LEN; k++)
            begin
                if (rx_store[k] !== HEADER_BYTES[k])
                begin
                    hdr_ok = 1'b0;
                end
            end
            if (hdr_ok)
            begin
                r.direction = field_to_milli(DIR_OFFSET);
                r.speed     = field_to_milli(SPD_OFFSET);
                wind_expected.push_back(r);
                readings_predicted++;
            end
            rx_count = 0;
        end
        if (rx_count < SENT_BYTES)
        begin
            if (rx_count < STORE_DEPTH)
            begin
                rx_store[rx_count] = c;
            end
            rx_count++;
        end
    endfunction

    function automatic void log_mismatch(input string why, input wind_reading_t want);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected dir %0d spd %0d, got dir %0d spd %0d",
                     $realtime, why, want.direction, want.speed,
                     wind_direction_milli, wind_speed_milli);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge. The input side
    // feeds the predictor, the output side is checked against the oldest
    // expected reading.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        wind_reading_t want;
        if (rst_n)
        begin
            if (rx_valid && !rx_stall)
            begin
                track_sentence(rx_byte);
            end
            if (wind_valid && !wind_stall)
            begin
                if (wind_expected.size() == 0)
                begin
                    want.direction = '0;
                    want.speed     = '0;
                    log_mismatch("reading with none expected", want);
                end
                else
                begin
                    want = wind_expected.pop_front();
                    if (wind_direction_milli !== want.direction ||
                        wind_speed_milli !== want.speed)
                    begin
                        log_mismatch("wrong reading", want);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Reading side: random stall, or a long hold-off counted down here
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left  = hold_left - 1;
            wind_stall <= 1'b1;
        end
        else
        begin
            wind_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------
    // Called at a rising edge; returns at the edge that takes the item.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    function automatic logic [7:0] any_but_dollar();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(255));
        end
        while (b == CHAR_DOLLAR);
        return b;
    endfunction

    // Mostly digits, sometimes a sign, a point or some other byte
    function automatic field_t rand_field();
        field_t f;
        int     r;
        for (int k = 0; k < FIELD_LEN; k++)
        begin
            r = $urandom_range(99);
            if (k == 0 && r < 20)
            begin
                f[k] = (r < 14) ? CHAR_MINUS : CHAR_PLUS;
            end
            else if (r < 70)
            begin
                f[k] = CHAR_ZERO + 8'($urandom_range(9));
            end
            else if (r < 84)
            begin
                f[k] = CHAR_POINT;
            end
            else
            begin
                f[k] = any_but_dollar();
            end
        end
        return f;
    endfunction

    // Sends the first len bytes of header, ',', direction, ",R,", speed;
    // beyond the twentieth byte the tail is random (never '$'). The next
    // '$' closes the sentence.
    task automatic send_sentence(input header_t hdr, input field_t dir,
                                 input field_t spd, input int len);
        logic [0:STORE_DEPTH-1][7:0] body;
        body = {hdr, ",", dir, ",R,", spd};
        for (int k = 0; k < len; k++)
        begin
            if (k < STORE_DEPTH)
            begin
                send_byte(body[k]);
            end
            else
            begin
                send_byte(any_but_dollar());
            end
        end
    endtask

    // Close the open sentence, then pause until every reading is in
    task automatic flush_readings();
        send_byte(CHAR_DOLLAR);
        rx_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (wind_expected.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Leading '$' with nothing held, then a header-only sentence: fields
    // read the zeroed store.
    task automatic test_reset_state();
        send_sentence(HEADER_BYTES, "00000", "00000", HEADER_LEN);
    endtask

    task automatic test_field_forms();
        send_sentence(HEADER_BYTES, "99999", "-9999", STORE_DEPTH);
        send_sentence(HEADER_BYTES, ".0005", "+1.25", STORE_DEPTH);
        send_sentence(HEADER_BYTES, "- 1.2", ". 5  ", STORE_DEPTH);   // lone sign, lone point
        send_sentence(HEADER_BYTES, ",,,,,", "0.004", STORE_DEPTH);   // empty field
        send_sentence(HEADER_BYTES, "1.999", "-0.00", STORE_DEPTH);
        send_sentence(HEADER_BYTES, {"1", 8'h00, "234"}, {"+9", 8'hFF, "99"}, STORE_DEPTH);
        send_sentence(HEADER_BYTES, "9999.", ".9995", STORE_DEPTH);
        send_sentence(HEADER_BYTES, "-.000", "12.34", STORE_DEPTH);
    endtask

    // Only the header matters here, so just the header is sent
    task automatic test_bad_headers();
        send_sentence("$IIMWX", "12345", "54321", HEADER_LEN);
        send_sentence({"$II", 8'h00, "WV"}, "12345", "54321", HEADER_LEN);
        send_sentence({"$IIMW", 8'hFF}, "12345", "54321", HEADER_LEN);
        send_sentence("$GPMWV", "12345", "54321", HEADER_LEN);
    endtask

    // Short sentences read what the longer one before them left behind;
    // a lone '$' still matches on the stale header.
    task automatic test_short_sentence();
        send_sentence(HEADER_BYTES, "270.5", "-3.75", STORE_DEPTH);
        send_sentence(HEADER_BYTES, "8    ", "     ", 9);
        send_sentence(HEADER_BYTES, "     ", "     ", 1);
    endtask

    // Tail runs past the buffer length; extra bytes are dropped
    task automatic test_long_sentence();
        send_sentence(HEADER_BYTES, "+45.6", "7.891", SENT_BYTES + 11);
    endtask

    // Reading side holds off while header-only sentences keep coming,
    // each closing one reading on stale fields: the queue fills and
    // rx_stall must rise.
    task automatic test_backpressure();
        hold_req = 200;
        for (int n = 0; n < 10; n++)
        begin
            send_sentence(HEADER_BYTES, rand_field(), rand_field(), HEADER_LEN);
        end
        flush_readings();
    endtask

    // Mostly well-formed sentences with random fields and lengths, some
    // with a damaged header, the rest raw noise that may include '$'.
    task automatic test_random_traffic(input int n_bytes, input int n_readings);
        int      b0;
        int      r0;
        int      lpick;
        int      len;
        header_t hdr;
        b0 = bytes_sent;
        r0 = readings_predicted;
        while (bytes_sent - b0 < n_bytes || readings_predicted - r0 < n_readings)
        begin
            if ($urandom_range(99) < 75)
            begin
                hdr = HEADER_BYTES;
                if ($urandom_range(9) == 0)
                begin
                    hdr[$urandom_range(1, HEADER_LEN - 1)] = any_but_dollar();
                end
                lpick = $urandom_range(9);
                if (lpick < 8)
                begin
                    len = $urandom_range(STORE_DEPTH, STORE_DEPTH + 10);
                end
                else if (lpick == 8)
                begin
                    len = $urandom_range(1, STORE_DEPTH - 1);
                end
                else
                begin
                    len = $urandom_range(SENT_BYTES - 4, SENT_BYTES + 16);
                end
                send_sentence(hdr, rand_field(), rand_field(), len);
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    send_byte(8'($urandom_range(255)));
                end
            end
        end
        flush_readings();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_field_forms();
        test_bad_headers();
        test_short_sentence();
        test_long_sentence();
        flush_readings();

        test_random_traffic(25, 1);

        send_idle_pct = 52;
        recv_idle_pct = 26;
        test_random_traffic(25, 1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_traffic(25, 1);

        repeat (LATENCY * 4) @(posedge clk);
        mismatches += wind_expected.size();
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/nwsp_pkg.sv
sv/nwsp_front.sv
sv/nwsp_queue.sv
sv/nwsp_back.sv
sv/nmea_wind_sentence_parser.sv
bench/tb_top.sv
